FILE: src/dpnm_pkg.sv
// shared types, constants and the reciprocal table of the neighbor mean filter
`timescale 1ns / 1ps
package dpnm_pkg;

    localparam int NB_COUNT    = 8;
    localparam int CHAN_COUNT  = 3;
    localparam int CHAN_W      = 8;
    localparam int COLOR_W     = CHAN_COUNT * CHAN_W;
    localparam int PAIR_COUNT  = NB_COUNT / 2;
    localparam int PAIR_W      = CHAN_W + 1;
    localparam int SUM_W       = CHAN_W + 3;
    localparam int CNT_W       = 4;
    localparam int NUMER_W     = SUM_W + 1;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = 16;
    localparam int PROD_W      = NUMER_W + RECIP_W;

    localparam logic [CHAN_W-1:0] LIMIT_RESET = 8'd16;

    typedef logic [COLOR_W-1:0] color_t;
    typedef logic [CHAN_W-1:0]  chan_t;

    // after compare: pair sums per channel, count, dissimilar flag, center
    typedef struct packed {
        logic [CHAN_COUNT-1:0][PAIR_COUNT-1:0][PAIR_W-1:0] pair_sum;
        logic [CNT_W-1:0]                                  count;
        logic                                              any_dis;
        color_t                                            center;
    } s1_t;

    // after reduce: rounding numerators, reciprocal of the divisor, replaced flag, center
    typedef struct packed {
        logic [CHAN_COUNT-1:0][NUMER_W-1:0] numer;
        logic [RECIP_W-1:0]                 recip;
        logic                               replaced;
        color_t                             center;
    } s2_t;

    // result of one transaction
    typedef struct packed {
        color_t out_color;
        logic   replaced;
    } s3_t;

    // ceil(2^16 / (2*count)); exact floor division for numerators below 4096
    function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] count);
        logic [RECIP_W-1:0] r;
        unique case (count)
            4'd1:    r = 16'd32768;
            4'd2:    r = 16'd16384;
            4'd3:    r = 16'd10923;
            4'd4:    r = 16'd8192;
            4'd5:    r = 16'd6554;
            4'd6:    r = 16'd5462;
            4'd7:    r = 16'd4682;
            4'd8:    r = 16'd4096;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: src/dpnm_compare.sv
// first stage: neighbor masking, similarity compare, pair sums and count
`timescale 1ns / 1ps
module dpnm_compare (
    input  logic                                                 aclk,
    input  logic                                                 aresetn,
    input  logic [dpnm_pkg::CHAN_W-1:0]                          limit,
    input  logic                                                 in_valid,
    output logic                                                 in_ready,
    input  dpnm_pkg::color_t                                     center,
    input  logic [dpnm_pkg::NB_COUNT-1:0][dpnm_pkg::COLOR_W-1:0] neighbors,
    input  logic [dpnm_pkg::NB_COUNT-1:0]                        present,
    output logic                                                 out_valid,
    input  logic                                                 out_ready,
    output dpnm_pkg::s1_t                                        out_data
);
    import dpnm_pkg::*;

    logic valid_reg;
    s1_t  data_reg;
    s1_t  data_next;

    logic [NB_COUNT-1:0][CHAN_COUNT-1:0][CHAN_W-1:0] nb_masked;
    logic [NB_COUNT-1:0]                             nb_dis;

    // per neighbor channel masking and absolute difference test
    always_comb begin
        chan_t x;
        chan_t y;
        chan_t d;
        nb_dis = '0;
        for (int i = 0; i < NB_COUNT; i++) begin
            for (int c = 0; c < CHAN_COUNT; c++) begin
                x = center[c*CHAN_W +: CHAN_W];
                y = neighbors[i][c*CHAN_W +: CHAN_W];
                d = (x > y) ? (x - y) : (y - x);
                nb_masked[i][c] = present[i] ? y : '0;
                if (present[i] && (d > limit)) begin
                    nb_dis[i] = 1'b1;
                end
            end
        end
    end

    // pair sums, present count and the stage payload
    always_comb begin
        data_next = '0;
        for (int c = 0; c < CHAN_COUNT; c++) begin
            for (int p = 0; p < PAIR_COUNT; p++) begin
                data_next.pair_sum[c][p] = PAIR_W'(nb_masked[2*p][c])
                                         + PAIR_W'(nb_masked[2*p+1][c]);
            end
        end
        for (int i = 0; i < NB_COUNT; i++) begin
            data_next.count = data_next.count + CNT_W'(present[i]);
        end
        data_next.any_dis = |nb_dis;
        data_next.center  = center;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: src/dpnm_reduce.sv
// second stage: channel sums, rounding numerators and reciprocal lookup
`timescale 1ns / 1ps
module dpnm_reduce (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  dpnm_pkg::s1_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output dpnm_pkg::s2_t out_data
);
    import dpnm_pkg::*;

    logic valid_reg;
    s2_t  data_reg;
    s2_t  data_next;

    // numerator 2*sum + count per channel
    always_comb begin
        logic [SUM_W-1:0] sum;
        data_next = '0;
        for (int c = 0; c < CHAN_COUNT; c++) begin
            sum = '0;
            for (int p = 0; p < PAIR_COUNT; p++) begin
                sum = sum + SUM_W'(in_data.pair_sum[c][p]);
            end
            data_next.numer[c] = {sum, 1'b0} + NUMER_W'(in_data.count);
        end
        data_next.recip    = recip_of(in_data.count);
        data_next.replaced = in_data.any_dis && (in_data.count != '0);
        data_next.center   = in_data.center;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: src/dpnm_divide.sv
// third stage: reciprocal multiply for the mean and output select
`timescale 1ns / 1ps
module dpnm_divide (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  dpnm_pkg::s2_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output dpnm_pkg::s3_t out_data
);
    import dpnm_pkg::*;

    logic valid_reg;
    s3_t  data_reg;
    s3_t  data_next;

    // mean = floor(numer * recip / 2^16), then pick mean or center
    always_comb begin
        logic [PROD_W-1:0] prod;
        color_t            mean;
        mean = '0;
        for (int c = 0; c < CHAN_COUNT; c++) begin
            prod = PROD_W'(in_data.numer[c]) * PROD_W'(in_data.recip);
            mean[c*CHAN_W +: CHAN_W] = prod[RECIP_SHIFT +: CHAN_W];
        end
        data_next.out_color = in_data.replaced ? mean : in_data.center;
        data_next.replaced  = in_data.replaced;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: src/dissimilar_pixel_neighbor_mean.sv
// top level of the selective 3x3 neighbor mean filter for RGB888 pixels
`timescale 1ns / 1ps
// Usage:
// - input stream s_*: one transaction carries a center pixel and its eight
//   neighbors in s_tdata, and the neighbor presence mask in s_tuser
// - output stream m_*: one transaction per input transaction, the filtered
//   color in m_tdata and the replaced flag in m_tuser, in input order
// - cfg_we / cfg_wdata write the similarity limit; write only while idle
// - three register stages (compare, sum/reciprocal lookup, multiply/select)
//   lie between s_* and m_*; m_tvalid and the result come from the last of
//   them
// - throughput is one transaction per cycle while m_tready is high; each stage holds one item
// - when m_tready is low the stages fill; s_tready drops only once all
//   three stages hold an item, so up to three items wait inside
// - nothing is lost or repeated across a stall; bubbles are squeezed out
// - reset (aresetn low, synchronous) empties the pipeline and sets the
//   similarity limit to 16
// - the mean per channel is rounded half up; with no neighbor present the
//   center passes unchanged and replaced is 0
module dissimilar_pixel_neighbor_mean (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [7:0]   cfg_wdata,   // similarity_limit
    input  logic         s_tvalid,
    output logic         s_tready,
    // center_color, neighbor_up_left, neighbor_up, neighbor_up_right,
    // neighbor_left, neighbor_right, neighbor_down_left, neighbor_down,
    // neighbor_down_right (24 bits each)
    input  logic [215:0] s_tdata,
    input  logic [7:0]   s_tuser,     // neighbor_present
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,     // out_color
    output logic         m_tuser      // replaced
);
    import dpnm_pkg::*;

    logic [CHAN_W-1:0] limit_reg;

    logic [NB_COUNT-1:0][COLOR_W-1:0] neighbors;

    logic s1_valid;
    logic s1_ready;
    s1_t  s1_data;
    logic s2_valid;
    logic s2_ready;
    s2_t  s2_data;
    s3_t  s3_data;

    // similarity limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_we) begin
            limit_reg <= cfg_wdata;
        end
    end

    // unpack neighbors from the data word
    always_comb begin
        for (int i = 0; i < NB_COUNT; i++) begin
            neighbors[i] = s_tdata[COLOR_W*(i+1) +: COLOR_W];
        end
    end

    dpnm_compare u_compare (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .limit     (limit_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .center    (s_tdata[COLOR_W-1:0]),
        .neighbors (neighbors),
        .present   (s_tuser),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    dpnm_reduce u_reduce (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    dpnm_divide u_divide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (s3_data)
    );

    assign m_tdata = s3_data.out_color;
    assign m_tuser = s3_data.replaced;

endmodule
